// ===== rtl/cse_pkg.sv =====
// shared constants, types and command/status structs for the cosine similarity engine
`default_nettype none

package cse_pkg;

	localparam int unsigned MAX_LENGTH = 4096;
	localparam int unsigned CNT_W      = $clog2(MAX_LENGTH + 1);

	localparam int unsigned ELEM_W = 16;
	localparam int unsigned PROD_W = 2 * ELEM_W;
	localparam int unsigned SQ_W   = 2 * ELEM_W - 1;
	localparam int unsigned DOT_W  = 44;
	localparam int unsigned NORM_W = 43;

	localparam int unsigned HALF_W = (DOT_W + 1) / 2;
	localparam int unsigned PP_W   = 2 * HALF_W;
	localparam int unsigned WIDE_W = 4 * HALF_W;

	localparam int unsigned Q_W      = 15;
	localparam int unsigned SIM_W    = 16;
	localparam int unsigned SRCH_W   = 122;
	localparam int unsigned ONE_Q14  = 16384;

	localparam int unsigned MUL_STEPS  = 8;
	localparam int unsigned SRCH_STEPS = 2 * Q_W;
	localparam int unsigned STEP_W     = $clog2(SRCH_STEPS + 1);

	typedef enum logic [2:0] {
		ST_ACC,
		ST_DRAIN,
		ST_MUL,
		ST_SEARCH,
		ST_DONE
	} cse_state_t;

	typedef struct packed {
		logic       accept;
		logic       snap;
		logic       mul_issue;
		logic [2:0] mul_idx;
		logic       search_init;
		logic       search_ph0;
		logic       search_ph1;
		logic       out_load;
	} cse_cmd_t;

	typedef struct packed {
		logic s1_busy;
		logic zero_norm;
		logic out_full;
	} cse_sts_t;

endpackage

`default_nettype wire

// ===== rtl/cosine_similarity_engine.sv =====
// top level of the cosine similarity engine
//
// Element pairs stream in at one item per cycle for as long as a vector lasts.
// After the item marked tlast the input stalls while the engine drains the
// product pipeline, forms the norm product and dot square on a single shared
// 22x22 multiplier, runs the 15-bit ratio search one result bit at a time and
// loads the result register once it is free; a zero norm skips the multiply
// and search. The next vector may start streaming while the previous result
// still waits in the output register.
`default_nettype none

module cosine_similarity_engine import cse_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // elem_a [15:0], elem_b [31:16]
	input  wire logic        s_axis_tlast,  // last_elem
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // similarity [15:0]
	output logic [1:0]       m_axis_tuser   // zero_norm [0], overflow (length or saturation) [1]
);

	cse_cmd_t                cmd;
	cse_sts_t                sts;
	logic signed [DOT_W-1:0] dot_acc;
	logic [NORM_W-1:0]       norm_a_acc;
	logic [NORM_W-1:0]       norm_b_acc;
	logic                    overflow_seen;
	logic                    s1_busy;
	logic                    zero_norm;
	logic                    out_full;

	assign sts.s1_busy   = s1_busy;
	assign sts.zero_norm = zero_norm;
	assign sts.out_full  = out_full;

	cse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	cse_accum u_accum (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.elem_a          (s_axis_tdata[ELEM_W-1:0]),
		.elem_b          (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
		.last_elem       (s_axis_tlast),
		.dot_acc_q       (dot_acc),
		.norm_a_acc_q    (norm_a_acc),
		.norm_b_acc_q    (norm_b_acc),
		.overflow_seen_q (overflow_seen),
		.s1_busy         (s1_busy)
	);

	cse_ratio u_ratio (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.dot_acc       (dot_acc),
		.norm_a_acc    (norm_a_acc),
		.norm_b_acc    (norm_b_acc),
		.overflow_seen (overflow_seen),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.zero_norm     (zero_norm),
		.out_full      (out_full)
	);

endmodule

`default_nettype wire

// ===== rtl/cse_accum.sv =====
// accumulation datapath: products, saturating sums, pair count and sticky overflow
`default_nettype none

module cse_accum import cse_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cse_cmd_t                 cmd,
	input  wire logic signed [ELEM_W-1:0] elem_a,
	input  wire logic signed [ELEM_W-1:0] elem_b,
	input  wire logic                     last_elem,
	output logic signed [DOT_W-1:0]       dot_acc_q,
	output logic        [NORM_W-1:0]      norm_a_acc_q,
	output logic        [NORM_W-1:0]      norm_b_acc_q,
	output logic                          overflow_seen_q,
	output logic                          s1_busy
);

	logic [CNT_W-1:0]         pair_count_q;
	logic                     full;
	logic                     vld_s1;
	logic                     over_s1;
	logic signed [PROD_W-1:0] ab_s1;
	logic [SQ_W-1:0]          aa_s1;
	logic [SQ_W-1:0]          bb_s1;
	logic signed [PROD_W-1:0] ab_full;
	logic signed [PROD_W-1:0] aa_full;
	logic signed [PROD_W-1:0] bb_full;
	logic signed [DOT_W:0]    dot_sum;
	logic [NORM_W:0]          na_sum;
	logic [NORM_W:0]          nb_sum;
	logic signed [DOT_W-1:0]  dot_next;
	logic [NORM_W-1:0]        na_next;
	logic [NORM_W-1:0]        nb_next;
	logic                     sat;

	assign full    = (pair_count_q >= CNT_W'(MAX_LENGTH));
	assign ab_full = elem_a * elem_b;
	assign aa_full = elem_a * elem_a;
	assign bb_full = elem_b * elem_b;
	assign s1_busy = vld_s1;

	// pair count and stage 1 product registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q <= '0;
			vld_s1       <= 1'b0;
			over_s1      <= 1'b0;
		end else begin
			vld_s1 <= cmd.accept;
			if (cmd.accept) begin
				over_s1 <= full;
				if (last_elem) begin
					pair_count_q <= '0;
				end else if (!full) begin
					pair_count_q <= pair_count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ab_s1 <= ab_full;
			aa_s1 <= aa_full[SQ_W-1:0];
			bb_s1 <= bb_full[SQ_W-1:0];
		end
	end

	// saturating sums
	always_comb begin
		dot_sum = {dot_acc_q[DOT_W-1], dot_acc_q} + (DOT_W+1)'(ab_s1);
		na_sum  = {1'b0, norm_a_acc_q} + (NORM_W+1)'(aa_s1);
		nb_sum  = {1'b0, norm_b_acc_q} + (NORM_W+1)'(bb_s1);
		sat     = 1'b0;
		if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
			dot_next = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
			sat      = 1'b1;
		end else begin
			dot_next = dot_sum[DOT_W-1:0];
		end
		if (na_sum[NORM_W]) begin
			na_next = '1;
			sat     = 1'b1;
		end else begin
			na_next = na_sum[NORM_W-1:0];
		end
		if (nb_sum[NORM_W]) begin
			nb_next = '1;
			sat     = 1'b1;
		end else begin
			nb_next = nb_sum[NORM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_acc_q       <= '0;
			norm_a_acc_q    <= '0;
			norm_b_acc_q    <= '0;
			overflow_seen_q <= 1'b0;
		end else if (cmd.snap) begin
			dot_acc_q       <= '0;
			norm_a_acc_q    <= '0;
			norm_b_acc_q    <= '0;
			overflow_seen_q <= 1'b0;
		end else if (vld_s1) begin
			if (over_s1) begin
				overflow_seen_q <= 1'b1;
			end else begin
				dot_acc_q    <= dot_next;
				norm_a_acc_q <= na_next;
				norm_b_acc_q <= nb_next;
				if (sat) begin
					overflow_seen_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cse_ratio.sv =====
// final datapath: norm product, dot square, bitwise ratio search and result register
`default_nettype none

module cse_ratio import cse_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cse_cmd_t                cmd,
	input  wire logic signed [DOT_W-1:0] dot_acc,
	input  wire logic [NORM_W-1:0]       norm_a_acc,
	input  wire logic [NORM_W-1:0]       norm_b_acc,
	input  wire logic                    overflow_seen,
	input  wire logic                    m_axis_tready,
	output logic                         m_axis_tvalid,
	output logic [SIM_W-1:0]             m_axis_tdata,
	output logic [1:0]                   m_axis_tuser,
	output logic                         zero_norm,
	output logic                         out_full
);

	logic [NORM_W-1:0] na_q;
	logic [NORM_W-1:0] nb_q;
	logic [DOT_W-1:0]  mag_q;
	logic              neg_q;
	logic              zero_q;
	logic              ovf_q;
	logic [DOT_W-1:0]  mag_now;

	logic [HALF_W-1:0] op_a;
	logic [HALF_W-1:0] op_b;
	logic [PP_W-1:0]   pp_q;
	logic [1:0]        pp_sh_q;
	logic              pp_dst_q;
	logic              pp_vld_q;
	logic [WIDE_W-1:0] addend;
	logic [WIDE_W-1:0] prod_q;
	logic [WIDE_W-1:0] mag2_q;

	logic [SRCH_W-1:0] x_q;
	logic [SRCH_W-1:0] z_q;
	logic [SRCH_W-1:0] p4_q;
	logic [SRCH_W-1:0] t_q;
	logic [SRCH_W-1:0] rhs;
	logic [SRCH_W-1:0] cand;
	logic [SRCH_W-1:0] zsum;
	logic              fits;
	logic [Q_W-1:0]    q_q;
	logic [Q_W-1:0]    q_clamp;
	logic [SIM_W-1:0]  sim;
	logic              tvalid_q;

	assign mag_now   = dot_acc[DOT_W-1] ? (~dot_acc + 1'b1) : dot_acc;
	assign zero_norm = (norm_a_acc == '0) || (norm_b_acc == '0);

	// operand select for the shared 22x22 multiplier
	always_comb begin
		if (!cmd.mul_idx[2]) begin
			op_a = cmd.mul_idx[1] ? HALF_W'(na_q[NORM_W-1:HALF_W]) : na_q[HALF_W-1:0];
			op_b = cmd.mul_idx[0] ? HALF_W'(nb_q[NORM_W-1:HALF_W]) : nb_q[HALF_W-1:0];
		end else begin
			op_a = cmd.mul_idx[1] ? HALF_W'(mag_q[DOT_W-1:HALF_W]) : mag_q[HALF_W-1:0];
			op_b = cmd.mul_idx[0] ? HALF_W'(mag_q[DOT_W-1:HALF_W]) : mag_q[HALF_W-1:0];
		end
	end

	always_comb begin
		case (pp_sh_q)
			2'd0:    addend = WIDE_W'(pp_q);
			2'd1:    addend = WIDE_W'(pp_q) << HALF_W;
			default: addend = WIDE_W'(pp_q) << (2 * HALF_W);
		endcase
	end

	// one ratio bit per ph0/ph1 pair: candidate square times norm product against rhs
	assign rhs  = SRCH_W'(mag2_q) << (2 * Q_W);
	assign cand = t_q + z_q;
	assign fits = (cand <= rhs);
	assign zsum = fits ? (z_q + (p4_q << 1)) : z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_vld_q <= 1'b0;
		end else begin
			pp_vld_q <= cmd.mul_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			na_q   <= norm_a_acc;
			nb_q   <= norm_b_acc;
			mag_q  <= mag_now;
			neg_q  <= dot_acc[DOT_W-1];
			zero_q <= zero_norm;
			ovf_q  <= overflow_seen;
			prod_q <= '0;
			mag2_q <= '0;
			q_q    <= '0;
		end else begin
			if (cmd.mul_issue) begin
				pp_q     <= op_a * op_b;
				pp_sh_q  <= {1'b0, cmd.mul_idx[1]} + {1'b0, cmd.mul_idx[0]};
				pp_dst_q <= cmd.mul_idx[2];
			end
			if (pp_vld_q) begin
				if (pp_dst_q) begin
					mag2_q <= mag2_q + addend;
				end else begin
					prod_q <= prod_q + addend;
				end
			end
			if (cmd.search_init) begin
				x_q  <= SRCH_W'(prod_q);
				z_q  <= '0 - (SRCH_W'(prod_q) << (Q_W + 1));
				p4_q <= SRCH_W'(prod_q) << (2 * Q_W);
				q_q  <= '0;
			end
			if (cmd.search_ph0) begin
				t_q <= x_q + p4_q;
			end
			if (cmd.search_ph1) begin
				if (fits) begin
					x_q <= cand;
				end
				z_q  <= {zsum[SRCH_W-1], zsum[SRCH_W-1:1]};
				p4_q <= p4_q >> 2;
				q_q  <= {q_q[Q_W-2:0], fits};
			end
		end
	end

	assign q_clamp = (q_q > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : q_q;
	assign sim     = neg_q ? ('0 - SIM_W'(q_clamp)) : SIM_W'(q_clamp);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_axis_tdata <= sim;
			m_axis_tuser <= {ovf_q, zero_q};
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign out_full      = tvalid_q;

endmodule

`default_nettype wire

// ===== rtl/cse_ctrl.sv =====
// controller state machine: streaming, drain, multiply and search sequencing
`default_nettype none

module cse_ctrl import cse_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	input  wire cse_sts_t sts,
	output logic          in_ready,
	output cse_cmd_t      cmd
);

	cse_state_t        state_q;
	cse_state_t        state_d;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC: begin
				if (in_valid && in_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.s1_busy) begin
					state_d = sts.zero_norm ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == STEP_W'(MUL_STEPS)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (step_q == STEP_W'(SRCH_STEPS)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_full) begin
					state_d = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ST_ACC);
		cmd             = '0;
		cmd.accept      = in_ready && in_valid;
		cmd.snap        = (state_q == ST_DRAIN) && !sts.s1_busy;
		cmd.mul_issue   = (state_q == ST_MUL) && (step_q < STEP_W'(MUL_STEPS));
		cmd.mul_idx     = step_q[2:0];
		cmd.search_init = (state_q == ST_SEARCH) && (step_q == '0);
		cmd.search_ph0  = (state_q == ST_SEARCH) && (step_q != '0) && step_q[0];
		cmd.search_ph1  = (state_q == ST_SEARCH) && (step_q != '0) && !step_q[0];
		cmd.out_load    = (state_q == ST_DONE) && !sts.out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else if (state_q == ST_MUL || state_q == ST_SEARCH) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cse_checker.sv =====
// port-level checker for the cosine similarity engine and its bind
`default_nettype none

module cse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	// input stalls right after the last item of a vector
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input not stalled after last item");

	// zero norm forces a zero similarity
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'h0000)
		else $error("nonzero similarity with zero norm");

	// similarity stays within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd16384) &&
			($signed(m_axis_tdata) >= -16'sd16384))
		else $error("similarity out of range");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tuser))
		else $error("stalled result changed");

	// input side signals are only watched
	logic unused_in;
	assign unused_in = ^s_axis_tdata;

endmodule

bind cosine_similarity_engine cse_checker u_checker (.*);

`default_nettype wire
